### rtl/mebf_pkg.sv
// Shared types and constants for the multi-endpoint byte FIFO bank.
package mebf_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned EpW     = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 7;
  localparam int unsigned MaskW   = 8;
  // widest endpoint range the direction lookup has to cover
  localparam int unsigned MaxFifos = 16;

  typedef enum logic [OpW-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

### rtl/mebf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mebf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/multi_endpoint_byte_fifo_top.sv
// Top level of the multi-endpoint circular byte FIFO bank.
//
// Usage notes:
// - Command channel (in_valid_i / in_stall_o): one word per command carrying
//   opcode, endpoint, data byte and query direction. A word is taken at a
//   clock edge where in_valid_i is high and in_stall_o is low.
// - Response channel (out_valid_o / out_stall_i): exactly one response word per
//   command, in command order. Held steady while out_stall_i is high.
// - Config: cfg_we_i writes the endpoint direction mask (bit e = endpoint e is
//   IN). Write it only while no command is in flight.
// - Timing: a command passes through stage 1 and the response register before
//   its response is valid. The byte store RAM has registered read data; pointers
//   and counts are updated at accept, so a new command can be taken every cycle while in_stall_o is low.
// - Throughput is limited only by the response side: when out_stall_i holds,
//   the response register and the RAM read stage fill and in_stall_o rises.
// - Reset: all read/write pointers and byte counts go to zero, the direction
//   mask clears, both stages empty. No clearing pass; byte data in the RAM is
//   undefined until written, but is only ever read after being written.
module multi_endpoint_byte_fifo_top
  import mebf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH       = 64,
  parameter int unsigned HIGHEST_ENDPOINT = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [MaskW-1:0]   cfg_wdata_i,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [EpW-1:0]     endpoint_i,
  input  logic [ByteW-1:0]   byte_in_i,
  input  logic               query_direction_i,
  // response channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   byte_out_o,
  output logic [StatusW-1:0] status_o,
  output logic               pending_found_o,
  output logic [EpW-1:0]     pending_endpoint_o,
  output logic [FillW-1:0]   fill_level_o
);

  localparam int unsigned NumFifos = HIGHEST_ENDPOINT + 1;
  localparam int unsigned IdxW     = $clog2(NumFifos);
  localparam int unsigned PtrW     = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW     = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned RamDepth = NumFifos * FIFO_DEPTH;
  localparam int unsigned AddrW    = $clog2(RamDepth);

  // Per-endpoint control state (small, kept in flops).
  logic [PtrW-1:0]  rd_ptr_q [NumFifos];
  logic [PtrW-1:0]  rd_ptr_d [NumFifos];
  logic [PtrW-1:0]  wr_ptr_q [NumFifos];
  logic [PtrW-1:0]  wr_ptr_d [NumFifos];
  logic [CntW-1:0]  cnt_q    [NumFifos];
  logic [CntW-1:0]  cnt_d    [NumFifos];
  logic [MaskW-1:0] dir_mask_q;

  // Pipeline stage 1: waits for RAM read data.
  logic               s1_valid_q, s1_valid_d;
  logic               s1_rd_q, s1_rd_d;
  status_e            s1_status_q, s1_status_d;
  logic               s1_found_q, s1_found_d;
  logic [EpW-1:0]     s1_pend_q, s1_pend_d;
  logic [FillW-1:0]   s1_fill_q, s1_fill_d;

  // Response register.
  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   out_byte_q;
  status_e            out_status_q;
  logic               out_found_q;
  logic [EpW-1:0]     out_pend_q;
  logic [FillW-1:0]   out_fill_q;

  logic               out_load;
  logic               s1_free;
  logic               accept;

  // Addressed endpoint.
  logic [IdxW-1:0]    ep_idx;
  logic               ep_ok;
  logic [PtrW-1:0]    cur_rd;
  logic [PtrW-1:0]    cur_wr;
  logic [CntW-1:0]    cur_cnt;
  logic [PtrW-1:0]    nxt_rd;
  logic [PtrW-1:0]    nxt_wr;

  // Pending search.
  logic [MaxFifos-1:0] dir_ext;
  logic                q_found;
  logic [EpW-1:0]      q_pend;
  logic [CntW-1:0]     q_cnt;

  // RAM ports.
  logic               ram_we;
  logic               ram_re;
  logic [AddrW-1:0]   ram_waddr;
  logic [AddrW-1:0]   ram_raddr;
  logic [ByteW-1:0]   ram_rdata;

  // Handshake: response register takes stage 1 when empty or being drained;
  // stage 1 takes a new command when it is empty or moving on.
  assign out_load   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free    = !s1_valid_q || out_load;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  assign ep_idx  = IdxW'(endpoint_i);
  assign ep_ok   = int'(endpoint_i) < NumFifos;
  assign cur_rd  = rd_ptr_q[ep_idx];
  assign cur_wr  = wr_ptr_q[ep_idx];
  assign cur_cnt = cnt_q[ep_idx];
  assign nxt_rd  = (cur_rd == PtrW'(FIFO_DEPTH - 1)) ? '0 : cur_rd + PtrW'(1);
  assign nxt_wr  = (cur_wr == PtrW'(FIFO_DEPTH - 1)) ? '0 : cur_wr + PtrW'(1);

  assign ram_waddr = AddrW'(ep_idx) * AddrW'(FIFO_DEPTH) + AddrW'(cur_wr);
  assign ram_raddr = AddrW'(ep_idx) * AddrW'(FIFO_DEPTH) + AddrW'(cur_rd);

  // Fixed-priority search: lowest endpoint from 1 upward with matching
  // direction and a nonzero count. Endpoints without a mask bit read as OUT.
  assign dir_ext = {{(MaxFifos - MaskW){1'b0}}, dir_mask_q};

  always_comb begin
    q_found = 1'b0;
    q_pend  = '0;
    q_cnt   = '0;
    for (int e = NumFifos - 1; e >= 1; e--) begin
      if ((dir_ext[e] == query_direction_i) && (cnt_q[e] != '0)) begin
        q_found = 1'b1;
        q_pend  = EpW'(e);
        q_cnt   = cnt_q[e];
      end
    end
  end

  // Command decode and pointer/count update.
  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    s1_rd_d     = 1'b0;
    s1_status_d = ST_OK;
    s1_found_d  = 1'b0;
    s1_pend_d   = '0;
    s1_fill_d   = '0;
    if (opcode_i == OP_QUERY) begin
      s1_found_d = q_found;
      s1_pend_d  = q_pend;
      s1_fill_d  = FillW'(q_cnt);
    end else if (ep_ok) begin
      s1_fill_d = FillW'(cur_cnt);
      case (opcode_e'(opcode_i))
        OP_WRITE: begin
          if (cur_cnt == CntW'(FIFO_DEPTH)) begin
            s1_status_d = ST_FULL;
          end else begin
            ram_we           = accept;
            wr_ptr_d[ep_idx] = nxt_wr;
            cnt_d[ep_idx]    = cur_cnt + CntW'(1);
            s1_fill_d        = FillW'(cur_cnt + CntW'(1));
          end
        end
        OP_READ: begin
          if (cur_cnt == '0) begin
            s1_status_d = ST_EMPTY;
          end else begin
            ram_re           = accept;
            s1_rd_d          = 1'b1;
            rd_ptr_d[ep_idx] = nxt_rd;
            cnt_d[ep_idx]    = cur_cnt - CntW'(1);
            s1_fill_d        = FillW'(cur_cnt - CntW'(1));
          end
        end
        OP_CLEAR: begin
          rd_ptr_d[ep_idx] = '0;
          wr_ptr_d[ep_idx] = '0;
          cnt_d[ep_idx]    = '0;
          s1_fill_d        = '0;
        end
        default: begin
          s1_fill_d = FillW'(cur_cnt);
        end
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumFifos; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
      dir_mask_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        cnt_q    <= cnt_d;
      end
      if (cfg_we_i) begin
        dir_mask_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q     <= s1_rd_d;
      s1_status_q <= s1_status_d;
      s1_found_q  <= s1_found_d;
      s1_pend_q   <= s1_pend_d;
      s1_fill_q   <= s1_fill_d;
    end
    if (out_load) begin
      out_byte_q   <= s1_rd_q ? ram_rdata : '0;
      out_status_q <= s1_status_q;
      out_found_q  <= s1_found_q;
      out_pend_q   <= s1_pend_q;
      out_fill_q   <= s1_fill_q;
    end
  end

  // Byte store; read data holds while stage 1 is stalled (re only on accept).
  mebf_ram #(
    .Width (ByteW),
    .Depth (RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_in_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign byte_out_o         = out_byte_q;
  assign status_o           = out_status_q;
  assign pending_found_o    = out_found_q;
  assign pending_endpoint_o = out_pend_q;
  assign fill_level_o       = out_fill_q;

endmodule

### verif/tb_multi_endpoint_byte_fifo_top.sv
// Self-checking testbench for the multi-endpoint byte FIFO bank, with a built-in predictor.
module tb_multi_endpoint_byte_fifo_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mebf_pkg::*;

  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned FifoDepth = 64;
  localparam int unsigned HighestEp = 7;
  localparam int unsigned NumFifos  = HighestEp + 1;
  // cycles with no word moving on either side before the run is declared hung
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned ItemsPerPhase = 320;

  // one command word as the sender drives it
  typedef struct packed {
    opcode_e              op;
    logic [EpW-1:0]       ep;
    logic [ByteW-1:0]     data;
    logic                 qdir;
  } fifo_cmd_t;

  // one response word as the block should return it
  typedef struct packed {
    logic [ByteW-1:0]     byte_out;
    status_e              status;
    logic                 found;
    logic [EpW-1:0]       pend;
    logic [FillW-1:0]     fill;
  } fifo_resp_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [MaskW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [OpW-1:0]     opcode_i;
  logic [EpW-1:0]     endpoint_i;
  logic [ByteW-1:0]   byte_in_i;
  logic               query_direction_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ByteW-1:0]   byte_out_o;
  logic [StatusW-1:0] status_o;
  logic               pending_found_o;
  logic [EpW-1:0]     pending_endpoint_o;
  logic [FillW-1:0]   fill_level_o;

  multi_endpoint_byte_fifo_top #(
    .FIFO_DEPTH      (FifoDepth),
    .HIGHEST_ENDPOINT(HighestEp)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .endpoint_i        (endpoint_i),
    .byte_in_i         (byte_in_i),
    .query_direction_i (query_direction_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .byte_out_o        (byte_out_o),
    .status_o          (status_o),
    .pending_found_o   (pending_found_o),
    .pending_endpoint_o(pending_endpoint_o),
    .fill_level_o      (fill_level_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the FIFO bank and the direction mask.
  // Pointers are 6 bits wide so they wrap at the depth of 64 by themselves.
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] shadow_mem [NumFifos][FifoDepth];
  logic [5:0]       shadow_rd_ptr [NumFifos];
  logic [5:0]       shadow_wr_ptr [NumFifos];
  logic [FillW-1:0] shadow_fill [NumFifos];
  logic [MaskW-1:0] shadow_dir_mask;

  fifo_cmd_t  pending_cmd_q[$];    // words waiting for the driver
  fifo_resp_t expected_resp_q[$];  // responses owed by the block, oldest first

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_span;
  int unsigned stall_mode;
  bit          in_taken;           // command word accepted at the last rising edge

  // Apply one command to the shadow bank and return the response it owes.
  function automatic fifo_resp_t fifo_bank_predict(fifo_cmd_t c);
    fifo_resp_t r;
    int unsigned e;
    r = '0;
    if (c.op == OP_QUERY) begin
      // endpoint 0 is never searched; first hit wins
      for (e = 1; e <= HighestEp; e++) begin
        if (!r.found && shadow_dir_mask[e] == c.qdir && shadow_fill[e] != 0) begin
          r.found = 1'b1;
          r.pend  = e[EpW-1:0];
          r.fill  = shadow_fill[e];
        end
      end
    end else begin
      case (c.op)
        OP_WRITE: begin
          if (shadow_fill[c.ep] >= FifoDepth) begin
            r.status = ST_FULL;  // byte dropped
          end else begin
            shadow_mem[c.ep][shadow_wr_ptr[c.ep]] = c.data;
            shadow_wr_ptr[c.ep] = shadow_wr_ptr[c.ep] + 6'd1;
            shadow_fill[c.ep]   = shadow_fill[c.ep] + 7'd1;
          end
        end
        OP_READ: begin
          if (shadow_fill[c.ep] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.byte_out = shadow_mem[c.ep][shadow_rd_ptr[c.ep]];
            shadow_rd_ptr[c.ep] = shadow_rd_ptr[c.ep] + 6'd1;
            shadow_fill[c.ep]   = shadow_fill[c.ep] - 7'd1;
          end
        end
        default: begin
          shadow_rd_ptr[c.ep] = '0;
          shadow_wr_ptr[c.ep] = '0;
          shadow_fill[c.ep]   = '0;
        end
      endcase
      r.fill = shadow_fill[c.ep];
    end
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_cmd(opcode_e op, logic [EpW-1:0] ep, logic [ByteW-1:0] data,
                          logic qdir);
    fifo_cmd_t c;
    c.op   = op;
    c.ep   = ep;
    c.data = data;
    c.qdir = qdir;
    pending_cmd_q.push_back(c);
  endtask

  // Random traffic, mostly runs on one endpoint so FIFOs reach full, empty
  // and wrap their pointers; the rest is clears, queries and loose words.
  task automatic load_random_traffic(int unsigned n_items);
    int unsigned made;
    int unsigned pick;
    int unsigned run;
    int unsigned k;
    logic [EpW-1:0] ep;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 99);
      ep   = EpW'($urandom_range(0, NumFifos - 1));
      if (pick < 22) begin
        // fill run, long enough to overflow an empty FIFO
        run = $urandom_range(1, 80);
        for (k = 0; k < run; k++) push_cmd(OP_WRITE, ep, ByteW'($urandom), 1'($urandom));
      end else if (pick < 40) begin
        // drain run, often past empty
        run = $urandom_range(1, 70);
        for (k = 0; k < run; k++) push_cmd(OP_READ, ep, ByteW'($urandom), 1'($urandom));
      end else if (pick < 52) begin
        // streaming: write/read pairs walk the pointers around the ring
        run = $urandom_range(1, 40);
        for (k = 0; k < run; k++) begin
          push_cmd(OP_WRITE, ep, ByteW'($urandom), 1'($urandom));
          push_cmd(OP_READ, ep, ByteW'($urandom), 1'($urandom));
        end
        run = 2 * run;
      end else if (pick < 58) begin
        run = 1;
        push_cmd(OP_CLEAR, ep, ByteW'($urandom), 1'($urandom));
      end else if (pick < 75) begin
        run = 1;
        push_cmd(OP_QUERY, ep, ByteW'($urandom), 1'($urandom));
      end else begin
        run = 1;
        push_cmd(opcode_e'($urandom_range(0, 3)), ep, ByteW'($urandom), 1'($urandom));
      end
      made += run;
    end
  endtask

  // Direction mask writes happen only with the pipeline drained.
  task automatic set_direction_mask(logic [MaskW-1:0] m);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_dir_mask = m;
  endtask

  // Wait until every queued word went in and every response came back,
  // then give the pipeline a little slack.
  task automatic drain_block();
    while (pending_cmd_q.size() != 0 || in_valid_i || expected_resp_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: bursts of random length, random gaps between them.
  // A word stays on the bus until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_cmd
    fifo_cmd_t c;
    logic      send;
    if (!(in_valid_i && !in_taken)) begin
      send = 1'b0;
      if (rst_ni) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmd_q.size() != 0) begin
          c = pending_cmd_q.pop_front();
          opcode_i          <= c.op;
          endpoint_i        <= c.ep;
          byte_in_i         <= c.data;
          query_direction_i <= c.qdir;
          send = 1'b1;
          if (burst_left <= 1) begin
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid_i <= send;
    end
  end

  // ---------------------------------------------------------------------------
  // Response stall: modes of random length - free flowing, light, heavy, solid.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_stall
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = (stall_mode == 3) ? $urandom_range(2, 30) : $urandom_range(10, 80);
    end
    stall_span--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on command accept, compare on response accept,
  // and watch for a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    fifo_cmd_t  c;
    fifo_resp_t want;
    bit         resp_taken;
    in_taken   = rst_ni && in_valid_i && !in_stall_o;
    resp_taken = rst_ni && out_valid_o && !out_stall_i;
    if (in_taken) begin
      c.op   = opcode_e'(opcode_i);
      c.ep   = endpoint_i;
      c.data = byte_in_i;
      c.qdir = query_direction_i;
      expected_resp_q.push_back(fifo_bank_predict(c));
    end
    if (resp_taken) begin
      if (expected_resp_q.size() == 0) begin
        report_error("response word with nothing outstanding");
      end else begin
        want = expected_resp_q.pop_front();
        if (byte_out_o !== want.byte_out)
          report_error($sformatf("byte_out %0h, expected %0h", byte_out_o, want.byte_out));
        if (status_o !== want.status)
          report_error($sformatf("status %0d, expected %0d", status_o, want.status));
        if (pending_found_o !== want.found)
          report_error($sformatf("pending_found %0b, expected %0b",
                                 pending_found_o, want.found));
        if (pending_endpoint_o !== want.pend)
          report_error($sformatf("pending_endpoint %0d, expected %0d",
                                 pending_endpoint_o, want.pend));
        if (fill_level_o !== want.fill)
          report_error($sformatf("fill_level %0d, expected %0d", fill_level_o, want.fill));
      end
    end
    if (rst_ni) begin
      idle_cycles = (in_taken || resp_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TIMEOUT: no word moved for %0d cycles", IdleLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [MaskW-1:0] phase_mask [6];
    int unsigned      p;
    int unsigned      e;
    int unsigned      k;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    opcode_i          = OP_WRITE;
    endpoint_i        = '0;
    byte_in_i         = '0;
    query_direction_i = 1'b0;
    out_stall_i       = 1'b0;
    error_count       = 0;
    idle_cycles       = 0;
    burst_left        = 1;
    gap_left          = 0;
    stall_span        = 0;
    stall_mode        = 0;
    in_taken          = 1'b0;

    // shadow bank starts empty, mask clear
    shadow_dir_mask = '0;
    for (e = 0; e < NumFifos; e++) begin
      shadow_rd_ptr[e] = '0;
      shadow_wr_ptr[e] = '0;
      shadow_fill[e]   = '0;
      for (k = 0; k < FifoDepth; k++) shadow_mem[e][k] = '0;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Mask 0x0A: endpoints 1 and 3 are in, the rest out.
    set_direction_mask(8'h0A);
    push_cmd(OP_QUERY, 3'd0, 8'h00, 1'b1);  // nothing anywhere: not found
    push_cmd(OP_QUERY, 3'd7, 8'hFF, 1'b0);
    push_cmd(OP_READ,  3'd0, 8'h00, 1'b0);  // read of empty FIFO
    push_cmd(OP_WRITE, 3'd0, 8'h00, 1'b0);
    push_cmd(OP_WRITE, 3'd0, 8'hFF, 1'b1);
    push_cmd(OP_WRITE, 3'd7, 8'hA5, 1'b0);
    push_cmd(OP_WRITE, 3'd3, 8'h5A, 1'b1);
    push_cmd(OP_QUERY, 3'd0, 8'h00, 1'b0);  // endpoint 0 skipped, finds 7
    push_cmd(OP_QUERY, 3'd0, 8'h00, 1'b1);  // finds 3
    push_cmd(OP_READ,  3'd0, 8'h00, 1'b0);
    push_cmd(OP_READ,  3'd0, 8'hFF, 1'b1);
    push_cmd(OP_READ,  3'd0, 8'h00, 1'b0);  // empty again
    push_cmd(OP_CLEAR, 3'd3, 8'h00, 1'b0);
    push_cmd(OP_QUERY, 3'd0, 8'h00, 1'b1);  // in side now empty
    push_cmd(OP_CLEAR, 3'd7, 8'hFF, 1'b1);  // clear with data
    push_cmd(OP_CLEAR, 3'd0, 8'h00, 1'b0);  // clear of empty FIFO
    push_cmd(OP_WRITE, 3'd1, 8'h3C, 1'b0);
    push_cmd(OP_QUERY, 3'd0, 8'h00, 1'b1);  // lowest searched endpoint
    push_cmd(OP_READ,  3'd1, 8'h00, 1'b0);
    push_cmd(OP_QUERY, 3'd0, 8'h00, 1'b0);
    drain_block();

    // Random phases over a spread of direction settings, extremes included.
    phase_mask[0] = 8'h00;
    phase_mask[1] = 8'hFF;
    phase_mask[2] = 8'hAA;
    phase_mask[3] = 8'h55;
    phase_mask[4] = MaskW'($urandom);
    phase_mask[5] = MaskW'($urandom);
    for (p = 0; p < 6; p++) begin
      set_direction_mask(phase_mask[p]);
      load_random_traffic(ItemsPerPhase);
      drain_block();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/mebf_pkg.sv
rtl/mebf_ram.sv
rtl/multi_endpoint_byte_fifo_top.sv
verif/tb_multi_endpoint_byte_fifo_top.sv
